FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the dispatch block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The antecedent must imply the consequent at the same clock edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/llsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the least-loaded server dispatch block.
// Depends on nothing; used by the cell and the top level.
package llsd_pkg;

    localparam int NUM_SERVERS_DEF = 16;
    localparam int LOAD_W          = 32;
    localparam int SVC_W           = 16;
    localparam int SRV_W           = 4;
    localparam int CFG_W           = 5;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_JOB   = 1'b1;

    // Search token that travels down the chain of cells.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [LOAD_W-1:0] load;
    } llsd_tok_t;

endpackage

FILE: hw/rtl/least_loaded_server_dispatch_core.sv
`timescale 1ns / 1ps
// Least-loaded server dispatch. Each server load sits in its own cell of a chain; a search
// token walks the chain one cell per cycle and picks the least-loaded active server, lowest
// index on ties. A job beat makes two token passes before its result beat: one pass
// finds the server, its saturated load is written back in the next cycle, and a second
// pass launched after that write finds the next server. A clear beat zeroes every load
// with no token pass. Each pass walks the whole chain of NUM_SERVERS cells. The block
// takes one beat at a time and takes the next beat once the result has moved into the
// result register; that register lets the next beat in while a result still waits.
// Depends on llsd_pkg, llsd_cell and assert_macros.svh.
`include "assert_macros.svh"
module least_loaded_server_dispatch_core #(
    parameter int NUM_SERVERS = llsd_pkg::NUM_SERVERS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [llsd_pkg::SVC_W-1:0]  service_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [llsd_pkg::SRV_W-1:0]  assigned_server,
    output logic [llsd_pkg::SRV_W-1:0]  next_server,
    input  logic                        cfg_we,
    input  logic [llsd_pkg::CFG_W-1:0]  cfg_data
);

    localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CNT_W = $clog2(NUM_SERVERS + 1);
    localparam int LOAD_W = llsd_pkg::LOAD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN1,
        S_SCAN2,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic                          launch_reg, launch_next;
    logic                          clear_reg, clear_next;
    logic                          wr_en_reg, wr_en_next;
    logic [IDX_W-1:0]              wr_idx_reg, wr_idx_next;
    logic [LOAD_W-1:0]             wr_load_reg, wr_load_next;
    logic [llsd_pkg::SVC_W-1:0]    svc_reg, svc_next;
    logic [llsd_pkg::SRV_W-1:0]    res_assigned_reg, res_assigned_next;
    logic [llsd_pkg::SRV_W-1:0]    res_next_reg, res_next_next;
    logic                          out_valid_reg, out_valid_next;
    logic [llsd_pkg::SRV_W-1:0]    assigned_reg, assigned_next;
    logic [llsd_pkg::SRV_W-1:0]    next_reg, next_next;
    logic [llsd_pkg::CFG_W-1:0]    servers_reg, servers_next;

    logic [CNT_W-1:0]              active_count;
    logic [LOAD_W:0]               sum_full;
    logic [LOAD_W-1:0]             sum_sat;

    llsd_pkg::llsd_tok_t           tok [0:NUM_SERVERS];
    logic [IDX_W-1:0]              tok_idx [0:NUM_SERVERS];

    always_comb
    begin
        if (servers_reg == '0)
        begin
            active_count = CNT_W'(1);
        end
        else if (32'(servers_reg) > NUM_SERVERS)
        begin
            active_count = CNT_W'(NUM_SERVERS);
        end
        else
        begin
            active_count = CNT_W'(servers_reg);
        end
    end

    assign tok[0].valid = launch_reg;
    assign tok[0].found = 1'b0;
    assign tok[0].load  = '0;
    assign tok_idx[0]   = '0;

    for (genvar i = 0; i < NUM_SERVERS; i++)
    begin : g_cell
        llsd_cell #(
            .NUM_SERVERS(NUM_SERVERS),
            .CELL_IDX(i),
            .IDX_W(IDX_W),
            .CNT_W(CNT_W)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .clear(clear_reg),
            .wr_en(wr_en_reg),
            .wr_idx(wr_idx_reg),
            .wr_load(wr_load_reg),
            .active_count(active_count),
            .tok_in(tok[i]),
            .tok_in_idx(tok_idx[i]),
            .tok_out(tok[i+1]),
            .tok_out_idx(tok_idx[i+1])
        );
    end

    assign sum_full = {1'b0, tok[NUM_SERVERS].load}
                    + {{(LOAD_W + 1 - llsd_pkg::SVC_W){1'b0}}, svc_reg};
    assign sum_sat  = sum_full[LOAD_W] ? {LOAD_W{1'b1}} : sum_full[LOAD_W-1:0];

    always_comb
    begin
        state_next        = state_reg;
        launch_next       = 1'b0;
        clear_next        = 1'b0;
        wr_en_next        = 1'b0;
        wr_idx_next       = wr_idx_reg;
        wr_load_next      = wr_load_reg;
        svc_next          = svc_reg;
        res_assigned_next = res_assigned_reg;
        res_next_next     = res_next_reg;
        out_valid_next    = out_valid_reg;
        assigned_next     = assigned_reg;
        next_next         = next_reg;
        servers_next      = cfg_we ? cfg_data : servers_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == llsd_pkg::OP_CLEAR)
                    begin
                        clear_next        = 1'b1;
                        res_assigned_next = '0;
                        res_next_next     = '0;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        svc_next    = service_time;
                        launch_next = 1'b1;
                        state_next  = S_SCAN1;
                    end
                end
            end
            S_SCAN1:
            begin
                if (tok[NUM_SERVERS].valid)
                begin
                    wr_en_next        = 1'b1;
                    wr_idx_next       = tok_idx[NUM_SERVERS];
                    wr_load_next      = sum_sat;
                    res_assigned_next = llsd_pkg::SRV_W'(tok_idx[NUM_SERVERS]);
                    state_next        = S_SCAN2;
                end
            end
            S_SCAN2:
            begin
                // The second pass starts once the new load sits in its cell.
                if (wr_en_reg)
                begin
                    launch_next = 1'b1;
                end
                if (tok[NUM_SERVERS].valid)
                begin
                    res_next_next = llsd_pkg::SRV_W'(tok_idx[NUM_SERVERS]);
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    assigned_next  = res_assigned_reg;
                    next_next      = res_next_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            launch_reg       <= 1'b0;
            clear_reg        <= 1'b0;
            wr_en_reg        <= 1'b0;
            wr_idx_reg       <= '0;
            wr_load_reg      <= '0;
            svc_reg          <= '0;
            res_assigned_reg <= '0;
            res_next_reg     <= '0;
            out_valid_reg    <= 1'b0;
            assigned_reg     <= '0;
            next_reg         <= '0;
            servers_reg      <= llsd_pkg::CFG_W'(1);
        end
        else
        begin
            state_reg        <= state_next;
            launch_reg       <= launch_next;
            clear_reg        <= clear_next;
            wr_en_reg        <= wr_en_next;
            wr_idx_reg       <= wr_idx_next;
            wr_load_reg      <= wr_load_next;
            svc_reg          <= svc_next;
            res_assigned_reg <= res_assigned_next;
            res_next_reg     <= res_next_next;
            out_valid_reg    <= out_valid_next;
            assigned_reg     <= assigned_next;
            next_reg         <= next_next;
            servers_reg      <= servers_next;
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign assigned_server = assigned_reg;
    assign next_server     = next_reg;

    // A token leaving the chain always belongs to a running search.
    `ASSERT_IMPLY(a_tok_in_scan, tok[NUM_SERVERS].valid, (state_reg == S_SCAN1) || (state_reg == S_SCAN2), "token left the chain outside a search")
    // Server 0 is always active, so every finished search has a winner.
    `ASSERT_IMPLY(a_tok_found, tok[NUM_SERVERS].valid, tok[NUM_SERVERS].found, "search finished without a winner")
    // A clear never overlaps a load write or a token launch.
    `ASSERT_CLK(a_clear_alone, !(clear_reg && (wr_en_reg || launch_reg)), "clear overlaps a write or launch")
    // The active count stays within the chain.
    `ASSERT_CLK(a_count_range, (active_count != '0) && (32'(active_count) <= NUM_SERVERS), "active count out of range")

endmodule

FILE: hw/rtl/llsd_cell.sv
`timescale 1ns / 1ps
// One server cell: holds a server load and forwards the search token by one stage.
// Depends on llsd_pkg.
module llsd_cell #(
    parameter int NUM_SERVERS = llsd_pkg::NUM_SERVERS_DEF,
    parameter int CELL_IDX    = 0,
    parameter int IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1,
    parameter int CNT_W       = $clog2(NUM_SERVERS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [llsd_pkg::LOAD_W-1:0] wr_load,
    input  logic [CNT_W-1:0]            active_count,
    input  llsd_pkg::llsd_tok_t         tok_in,
    input  logic [IDX_W-1:0]            tok_in_idx,
    output llsd_pkg::llsd_tok_t         tok_out,
    output logic [IDX_W-1:0]            tok_out_idx
);

    logic [llsd_pkg::LOAD_W-1:0] load_reg;
    logic                        tok_valid_reg;
    logic                        tok_found_reg;
    logic [llsd_pkg::LOAD_W-1:0] tok_load_reg;
    logic [IDX_W-1:0]            tok_idx_reg;

    logic                        active;
    logic                        take;
    logic                        tok_found_next;
    logic [llsd_pkg::LOAD_W-1:0] tok_load_next;
    logic [IDX_W-1:0]            tok_idx_next;

    assign active = CNT_W'(CELL_IDX) < active_count;

    // Strict compare keeps the lowest index on ties.
    assign take = active && (!tok_in.found || (load_reg < tok_in.load));

    assign tok_found_next = tok_in.found | take;
    assign tok_load_next  = take ? load_reg : tok_in.load;
    assign tok_idx_next   = take ? IDX_W'(CELL_IDX) : tok_in_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg      <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
            if (clear)
            begin
                load_reg <= '0;
            end
            else if (wr_en && (wr_idx == IDX_W'(CELL_IDX)))
            begin
                load_reg <= wr_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_found_reg <= tok_found_next;
        tok_load_reg  <= tok_load_next;
        tok_idx_reg   <= tok_idx_next;
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.found = tok_found_reg;
    assign tok_out.load  = tok_load_reg;
    assign tok_out_idx   = tok_idx_reg;

endmodule

FILE: verif/least_loaded_server_dispatch_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for least_loaded_server_dispatch_core: it predicts every result beat
// of a 16-server core and checks it under random stalls on both sides.
// Depends on llsd_pkg and the RTL of the core.
module least_loaded_server_dispatch_core_tb;

    localparam int JOB_LATENCY    = 2 * llsd_pkg::NUM_SERVERS_DEF + 4;
    localparam int END_SETTLE     = JOB_LATENCY + 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_BEATS    = 48;

    typedef struct packed {
        logic [llsd_pkg::SRV_W-1:0] assigned;
        logic [llsd_pkg::SRV_W-1:0] next_srv;
    } dispatch_result_t;

    class server_load_model;
        static int unsigned          mismatches = 0;
        string                       label;
        int unsigned                 num_servers;
        int unsigned                 beats;
        logic [llsd_pkg::CFG_W-1:0]  servers_cfg;
        logic [llsd_pkg::LOAD_W-1:0] load[];
        dispatch_result_t            expected_dispatch_q[$];

        function new(string name, int unsigned count);
            label       = name;
            num_servers = count;
            beats       = 0;
            servers_cfg = llsd_pkg::CFG_W'(1);
            load        = new[count];
            foreach (load[i])
            begin
                load[i] = '0;
            end
        endfunction

        function void set_servers(logic [llsd_pkg::CFG_W-1:0] value);
            servers_cfg = value;
        endfunction

        function int unsigned least_loaded();
            int unsigned n;
            int unsigned best;
            n = 32'(servers_cfg);
            if (n < 1)
            begin
                n = 1;
            end
            if (n > num_servers)
            begin
                n = num_servers;
            end
            best = 0;
            for (int unsigned i = 1; i < n; i++)
            begin
                if (load[i] < load[best])
                begin
                    best = i;
                end
            end
            return best;
        endfunction

        function void apply_beat(logic op, logic [llsd_pkg::SVC_W-1:0] svc);
            dispatch_result_t              res;
            int unsigned                   srv;
            logic [llsd_pkg::LOAD_W:0]     sum;
            res.assigned = '0;
            if (op == llsd_pkg::OP_CLEAR)
            begin
                foreach (load[i])
                begin
                    load[i] = '0;
                end
            end
            else
            begin
                srv          = least_loaded();
                sum          = {1'b0, load[srv]}
                             + {{(llsd_pkg::LOAD_W + 1 - llsd_pkg::SVC_W){1'b0}}, svc};
                load[srv]    = sum[llsd_pkg::LOAD_W] ? '1 : sum[llsd_pkg::LOAD_W-1:0];
                res.assigned = srv[llsd_pkg::SRV_W-1:0];
            end
            srv          = least_loaded();
            res.next_srv = srv[llsd_pkg::SRV_W-1:0];
            expected_dispatch_q.push_back(res);
            beats++;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s", msg);
            end
        endfunction

        function void check_dispatch(logic [llsd_pkg::SRV_W-1:0] assigned,
                                     logic [llsd_pkg::SRV_W-1:0] next_srv);
            dispatch_result_t want;
            if (expected_dispatch_q.size() == 0)
            begin
                report($sformatf("%s: result beat with nothing pending (assigned %0d, next %0d)",
                                 label, assigned, next_srv));
                return;
            end
            want = expected_dispatch_q.pop_front();
            if (assigned !== want.assigned)
            begin
                report($sformatf("%s: assigned_server expected %0d, got %0d",
                                 label, want.assigned, assigned));
            end
            if (next_srv !== want.next_srv)
            begin
                report($sformatf("%s: next_server expected %0d, got %0d",
                                 label, want.next_srv, next_srv));
            end
        endfunction

        function int unsigned pending();
            return expected_dispatch_q.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        operation;
    logic [llsd_pkg::SVC_W-1:0]  service_time;
    logic                        out_valid;
    logic                        out_ready;
    logic [llsd_pkg::SRV_W-1:0]  assigned_server;
    logic [llsd_pkg::SRV_W-1:0]  next_server;
    logic                        cfg_we;
    logic [llsd_pkg::CFG_W-1:0]  cfg_data;

    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    bit                 main_done = 1'b0;
    int unsigned        settings_seen = 0;
    int unsigned        idle_cycles;

    server_load_model   main_model = new("core16", llsd_pkg::NUM_SERVERS_DEF);

    least_loaded_server_dispatch_core #(
        .NUM_SERVERS(llsd_pkg::NUM_SERVERS_DEF)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .service_time    (service_time),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .assigned_server (assigned_server),
        .next_server     (next_server),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        operation        = llsd_pkg::OP_CLEAR;
        service_time     = '0;
        out_ready        = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic send_item(logic op, logic [llsd_pkg::SVC_W-1:0] svc);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        service_time <= svc;
        do @(posedge clk); while (!in_ready);
        main_model.apply_beat(op, svc);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (main_model.pending() != 0) @(posedge clk);
    endtask

    task automatic write_servers(logic [llsd_pkg::CFG_W-1:0] value);
        drain_results();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        main_model.set_servers(value);
        cfg_we <= 1'b0;
        settings_seen++;
    endtask

    initial
    begin : main_stimulus
        logic                       op;
        logic [llsd_pkg::SVC_W-1:0] svc;
        logic [llsd_pkg::CFG_W-1:0] cfg_pick;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // A count of zero behaves as one server.
        write_servers(5'd0);
        send_item(llsd_pkg::OP_JOB, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'h0000);
        send_item(llsd_pkg::OP_CLEAR, 16'h0000);
        write_servers(5'd16);
        send_item(llsd_pkg::OP_JOB, 16'h0000);
        send_item(llsd_pkg::OP_JOB, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'h0001);
        send_item(llsd_pkg::OP_JOB, 16'h8000);
        send_item(llsd_pkg::OP_JOB, 16'h7FFF);
        write_servers(5'd31);
        send_item(llsd_pkg::OP_JOB, 16'h5555);
        send_item(llsd_pkg::OP_JOB, 16'hAAAA);
        send_item(llsd_pkg::OP_JOB, 16'h0001);
        // Shrinking and regrowing the count must bring back the idle servers' loads.
        write_servers(5'd3);
        send_item(llsd_pkg::OP_JOB, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'h0000);
        write_servers(5'd17);
        send_item(llsd_pkg::OP_JOB, 16'h0002);
        send_item(llsd_pkg::OP_JOB, 16'h0002);
        send_item(llsd_pkg::OP_CLEAR, 16'hFFFF);
        send_item(llsd_pkg::OP_JOB, 16'h1234);
        write_servers(5'd1);
        send_item(llsd_pkg::OP_JOB, 16'h00FF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       cfg_pick = 5'd16;
                1:       cfg_pick = 5'd1;
                2:       cfg_pick = 5'd0;
                3:       cfg_pick = 5'd31;
                4:       cfg_pick = 5'd15;
                5:       cfg_pick = 5'd2;
                default: cfg_pick = llsd_pkg::CFG_W'($urandom_range(0, 31));
            endcase
            write_servers(cfg_pick);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (phase == 4 && k == PHASE_BEATS / 2)
                begin
                    drain_results();
                end
                op = ($urandom_range(0, 11) == 0) ? llsd_pkg::OP_CLEAR : llsd_pkg::OP_JOB;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: svc = llsd_pkg::SVC_W'($urandom_range(0, 7));
                    4:          svc = 16'hFFFF;
                    5:          svc = 16'h0000;
                    default:    svc = llsd_pkg::SVC_W'($urandom_range(0, 16'hFFFF));
                endcase
                send_item(op, svc);
            end
        end
        drain_results();
        main_done = 1'b1;
    end

    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                main_model.check_dispatch(assigned_server, next_server);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : finish_run
        wait (main_done);
        repeat (END_SETTLE) @(posedge clk);
        $display("Dispatched %0d beats on the 16-server core over %0d server-count settings,",
                 main_model.beats, settings_seen);
        $display("including zero, shrinking and out-of-range counts under random stalls.");
        if (server_load_model::mismatches == 0 && main_model.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
